// ===== hw/rtl/cnnact_pkg.sv =====
package cnnact_pkg;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_LOGISTIC = 3'd1,
        ACT_RAMP     = 3'd2,
        ACT_LEAKY    = 3'd3,
        ACT_RELU     = 3'd4
    } act_mode_t;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last_out;
    } out_t;

    // 0.1 in Q0.16, rounded to nearest
    localparam logic signed [31:0] TENTH_NUM = 32'sd6554;
    localparam logic signed [31:0] TENTH_RND = 32'sd32768;

    localparam int ROM_W    = 17;   // sigmoid table entry, Q0.16 up to 1.0
    localparam int FRAC_W   = 11;   // interpolation fraction bits
    localparam logic [8:0] LOGISTIC_ONE = 9'd256;

    // Shift-subtract division, only ever evaluated at elaboration for the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-(8*i/depth) in Q2.30: series for i/(2*depth), then squared four times
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] i, input logic [63:0] depth);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] e;
        y     = udiv64(i << 30, depth << 1);
        term  = 64'd1 << 30;
        plus  = term;
        minus = '0;
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64((term * y) >> 30, 64'(n));
            if (n[0])
            begin
                minus = minus + term;
            end
            else
            begin
                plus = plus + term;
            end
        end
        e = (plus > minus) ? plus - minus : 64'd0;
        for (int k = 0; k < 4; k++)
        begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        return e;
    endfunction

    // sigmoid(8*i/depth) in Q0.16, rounded to nearest
    function automatic logic [ROM_W-1:0] sigmoid_entry(input logic [63:0] i,
                                                        input logic [63:0] depth);
        logic [63:0] den;
        logic [63:0] q;
        den = (64'd1 << 30) + exp_neg_q30(i, depth);
        q   = udiv64((64'd1 << 46) + (den >> 1), den);
        return q[ROM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/cnnact_sigmoid.sv =====
module cnnact_sigmoid #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic signed [15:0] sample,
    output logic signed [15:0] sigmoid
);

    localparam int AW = $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int PW = 17 + AW;
    localparam int IW = PW - cnnact_pkg::FRAC_W;
    localparam int VW = cnnact_pkg::ROM_W + cnnact_pkg::FRAC_W;

    typedef logic [cnnact_pkg::ROM_W-1:0] rom_t [0:SIGMOID_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i <= SIGMOID_TABLE_DEPTH; i++)
        begin
            t[i] = cnnact_pkg::sigmoid_entry(64'(i), 64'(SIGMOID_TABLE_DEPTH));
        end
        return t;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

    logic [16:0]                    mag;
    logic [PW-1:0]                  pos;
    logic [IW-1:0]                  seg;
    logic [cnnact_pkg::FRAC_W-1:0]  frac;
    logic                           beyond;
    logic [AW-1:0]                  idx;
    logic [AW-1:0]                  idx_up;
    logic [cnnact_pkg::ROM_W-1:0]   lo;
    logic [cnnact_pkg::ROM_W-1:0]   hi;
    logic [cnnact_pkg::ROM_W-1:0]   slope;
    logic [VW-1:0]                  interp;
    logic [VW-1:0]                  rounded;
    logic [8:0]                     p;
    logic [8:0]                     p_signed;

    always_comb
    begin
        mag    = sample[15] ? 17'(-{sample[15], sample}) : {1'b0, sample};
        pos    = PW'(mag) * PW'(SIGMOID_TABLE_DEPTH);
        seg    = pos[PW-1:cnnact_pkg::FRAC_W];
        frac   = pos[cnnact_pkg::FRAC_W-1:0];
        beyond = (seg >= IW'(SIGMOID_TABLE_DEPTH));
        idx    = beyond ? '0 : seg[AW-1:0];
        idx_up = idx + AW'(1);
        lo     = SIG_ROM[idx];
        hi     = SIG_ROM[idx_up];
        // table rises monotonically, so the slope is never negative
        slope   = hi - lo;
        interp  = {lo, {cnnact_pkg::FRAC_W{1'b0}}} + VW'(slope) * VW'(frac);
        rounded = interp + (VW'(1) << 18);
        p       = beyond ? cnnact_pkg::LOGISTIC_ONE : rounded[cnnact_pkg::FRAC_W + 8 +: 9];
        p_signed = sample[15] ? cnnact_pkg::LOGISTIC_ONE - p : p;
        sigmoid  = {7'd0, p_signed};
    end

endmodule

// ===== hw/rtl/cnnact_shape.sv =====
module cnnact_shape (
    input  logic signed [15:0]     sample,
    input  cnnact_pkg::act_mode_t  mode,
    input  logic signed [15:0]     sigmoid,
    output logic signed [15:0]     activated
);

    logic signed [31:0] scaled;
    logic signed [15:0] tenth;
    logic               positive;
    logic signed [16:0] ramp_sum;
    logic signed [15:0] ramp;

    always_comb
    begin
        // floor((x*6554 + 32768) / 65536); ties go up
        scaled   = 32'(sample) * cnnact_pkg::TENTH_NUM + cnnact_pkg::TENTH_RND;
        tenth    = scaled[31:16];
        positive = !sample[15] && (sample != 16'sd0);
        ramp_sum = (positive ? {sample[15], sample} : 17'sd0) + {tenth[15], tenth};
        if (ramp_sum > 17'sd32767)
        begin
            ramp = 16'sh7FFF;
        end
        else if (ramp_sum < -17'sd32768)
        begin
            ramp = 16'sh8000;
        end
        else
        begin
            ramp = ramp_sum[15:0];
        end

        unique case (mode)
            cnnact_pkg::ACT_LOGISTIC: activated = sigmoid;
            cnnact_pkg::ACT_RAMP:     activated = ramp;
            cnnact_pkg::ACT_LEAKY:    activated = positive ? sample : tenth;
            cnnact_pkg::ACT_RELU:     activated = positive ? sample : 16'sd0;
            default:                  activated = sample;
        endcase
    end

endmodule

// ===== hw/rtl/cnn_activation_unit_top.sv =====
// Channel     Handshake               Payload
// operand     start / busy            cnnact_pkg::in_t  (sample_in, last_in)
// result      done (strobe)           cnnact_pkg::out_t (sample_out, last_out)
// cfg         cfg_valid / cfg_ready   cfg_data, activation select
//
// One word per clock; busy never rises. The operand register captures the input, then
// the table lookup, interpolation and mode select feed the result register.
// The result shows for one cycle with done high; the receiver cannot stall it.
// rst_n clears the valid flags and sets the mode to pass-through.
module cnn_activation_unit_top #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cnnact_pkg::in_t      operand,
    output logic                 done,
    output cnnact_pkg::out_t     result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data
);

    cnnact_pkg::act_mode_t  mode_reg;
    cnnact_pkg::act_mode_t  mode_next;
    cnnact_pkg::in_t        operand_reg;
    logic                   operand_valid_reg;
    cnnact_pkg::out_t       result_reg;
    cnnact_pkg::out_t       result_next;
    logic                   done_reg;
    logic signed [15:0]     sigmoid;
    logic signed [15:0]     activated;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign mode_next = (cfg_valid && cfg_ready) ? cnnact_pkg::act_mode_t'(cfg_data) : mode_reg;

    cnnact_sigmoid #(
        .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
    ) u_sigmoid (
        .sample  (operand_reg.sample_in),
        .sigmoid (sigmoid)
    );

    cnnact_shape u_shape (
        .sample    (operand_reg.sample_in),
        .mode      (mode_reg),
        .sigmoid   (sigmoid),
        .activated (activated)
    );

    always_comb
    begin
        result_next.sample_out = activated;
        result_next.last_out   = operand_reg.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= cnnact_pkg::ACT_NONE;
            operand_valid_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            mode_reg          <= mode_next;
            operand_valid_reg <= start && !busy;
            done_reg          <= operand_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            operand_reg <= operand;
        end
        if (operand_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule
